FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the heightfield triangle emitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define HTE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define HTE_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HTE_ASSERT(label, clk, rst, prop, msg)
`define HTE_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: sv/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Types and constants shared by the heightfield triangle emitter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hte_pkg;

   // Grid geometry.
   localparam int MAX_COLUMNS = 1024;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int COL_CNT_W   = 11;
   localparam int ROW_W       = 16;
   localparam int HEIGHT_W    = 16;
   localparam int MAT_W       = 7;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'b1;
   localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_RESET = 11'd2;
   localparam logic [ROW_W-1:0]     ROW_COUNT_RESET    = 16'd2;
   localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_MIN   = 11'd2;
   localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_MAX   = COL_CNT_W'(MAX_COLUMNS);
   localparam logic [ROW_W-1:0]     ROW_COUNT_MIN      = 16'd2;

   // Material code that marks a missing triangle.
   localparam logic [MAT_W-1:0] HOLE_MATERIAL = 7'd127;

   // Corner patterns of an emitted triangle.
   localparam logic [1:0] PAT_SPLIT_FIRST    = 2'd0;
   localparam logic [1:0] PAT_SPLIT_SECOND   = 2'd1;
   localparam logic [1:0] PAT_UNSPLIT_FIRST  = 2'd2;
   localparam logic [1:0] PAT_UNSPLIT_SECOND = 2'd3;

   // One heightfield sample, also the layout of a line store entry.
   typedef struct packed {
      logic [MAT_W-1:0]           second_material;
      logic [MAT_W-1:0]           first_material;
      logic                       split_flag;
      logic signed [HEIGHT_W-1:0] sample_height;
   } sample_type;

   // Grid position of a sample.
   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
   } position_type;

   // One emitted triangle.
   typedef struct packed {
      logic [COL_W-1:0]           cell_column;
      logic [ROW_W-1:0]           cell_row;
      logic [1:0]                 corner_pattern;
      logic signed [HEIGHT_W-1:0] height_one;
      logic signed [HEIGHT_W-1:0] height_two;
      logic signed [HEIGHT_W-1:0] height_three;
      logic [MAT_W-1:0]           triangle_material;
      logic                       last_of_cell;
   } triangle_type;

endpackage

FILE: sv/hte_position.sv
// ----------------------------------------------------------------------------
// hte_position
// Configuration registers and the row/column position counters of the grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hte_position (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [hte_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hte_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                          advance,
   output hte_pkg::position_type         position
);
   import hte_pkg::*;

   logic [COL_CNT_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0]     row_count_ff, row_count_in;
   logic [COL_W-1:0]     column_ff, column_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_CNT_W-1:0] cols_eff;
   logic [ROW_W-1:0]     rows_eff;
   logic [COL_CNT_W-1:0] column_next;
   logic [ROW_W:0]       row_next;

   // Register writes.
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COLUMN_COUNT: column_count_in = csr_data[COL_CNT_W-1:0];
            CSR_ROW_COUNT:    row_count_in    = csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the bounds to the supported range.
   always_comb begin
      priority if (column_count_ff < COLUMN_COUNT_MIN) begin
         cols_eff = COLUMN_COUNT_MIN;
      end else if (column_count_ff > COLUMN_COUNT_MAX) begin
         cols_eff = COLUMN_COUNT_MAX;
      end else begin
         cols_eff = column_count_ff;
      end
      rows_eff = (row_count_ff < ROW_COUNT_MIN) ? ROW_COUNT_MIN : row_count_ff;
   end

   // Step the position once per accepted sample, wrapping at row and grid end.
   always_comb begin
      column_next = {1'b0, column_ff} + COL_CNT_W'(1);
      row_next    = {1'b0, row_ff} + (ROW_W+1)'(1);
      column_in   = column_ff;
      row_in      = row_ff;
      if (advance) begin
         if (column_next >= cols_eff) begin
            column_in = '0;
            row_in    = (row_next >= {1'b0, rows_eff}) ? '0 : row_next[ROW_W-1:0];
         end else begin
            column_in = column_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         row_count_ff    <= ROW_COUNT_RESET;
         column_ff       <= '0;
         row_ff          <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
      end
   end

   assign position.column = column_ff;
   assign position.row    = row_ff;

endmodule

FILE: sv/hte_line_store.sv
// ----------------------------------------------------------------------------
// hte_line_store
// Single-port line store holding the previous row of samples, read-first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hte_line_store (
   input  logic                      clock,
   input  logic                      access,
   input  logic [hte_pkg::COL_W-1:0] address,
   input  hte_pkg::sample_type       write_data,
   output hte_pkg::sample_type       read_data
);
   import hte_pkg::*;

   sample_type mem [MAX_COLUMNS];
   sample_type read_data_ff;

   // The old entry is read out while the new sample replaces it.
   always_ff @(posedge clock) begin
      if (access) begin
         read_data_ff  <= mem[address];
         mem[address]  <= write_data;
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: sv/hte_emit.sv
// ----------------------------------------------------------------------------
// hte_emit
// Work register for one sample and the result register for its triangles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hte_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hte_pkg::sample_type   sample,
   input  hte_pkg::position_type position,
   input  hte_pkg::sample_type   up_right,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hte_pkg::triangle_type rsp_tri
);
   import hte_pkg::*;

   // Work register state.
   logic         a_valid_ff, a_valid_in;
   sample_type   a_sample_ff;
   position_type a_pos_ff;
   logic         a_first_done_ff, a_first_done_in;
   sample_type   above_left_ff, above_left_in;
   logic signed [HEIGHT_W-1:0] left_height_ff, left_height_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   triangle_type rsp_tri_ff;

   logic closes_cell, has_first, has_second, emit_valid, emit_last, out_free;
   logic emit_fire, a_retire;
   logic signed [HEIGHT_W-1:0] ul, ur, ll, lr;
   triangle_type tri_sel;

   // Which triangles of the finished cell remain to be sent.
   always_comb begin
      closes_cell = (a_pos_ff.row != '0) && (a_pos_ff.column != '0);
      has_first   = closes_cell && (above_left_ff.first_material != HOLE_MATERIAL)
                    && !a_first_done_ff;
      has_second  = closes_cell && (above_left_ff.second_material != HOLE_MATERIAL);
      emit_valid  = a_valid_ff && (has_first || has_second);
      emit_last   = !has_first || !has_second;
      out_free    = !rsp_valid_ff || !rsp_stall;
      emit_fire   = emit_valid && out_free;
      a_retire    = a_valid_ff && (!(has_first || has_second) || (out_free && emit_last));
      free        = !a_valid_ff || a_retire;
   end

   // Build the triangle from the four corner heights.
   always_comb begin
      ul = above_left_ff.sample_height;
      ur = up_right.sample_height;
      ll = left_height_ff;
      lr = a_sample_ff.sample_height;
      tri_sel.cell_column  = a_pos_ff.column - COL_W'(1);
      tri_sel.cell_row     = a_pos_ff.row - ROW_W'(1);
      tri_sel.last_of_cell = emit_last;
      if (has_first) begin
         tri_sel.triangle_material = above_left_ff.first_material;
         if (above_left_ff.split_flag) begin
            tri_sel.corner_pattern = PAT_SPLIT_FIRST;
            tri_sel.height_one     = ul;
            tri_sel.height_two     = ll;
            tri_sel.height_three   = lr;
         end else begin
            tri_sel.corner_pattern = PAT_UNSPLIT_FIRST;
            tri_sel.height_one     = ur;
            tri_sel.height_two     = ul;
            tri_sel.height_three   = ll;
         end
      end else begin
         tri_sel.triangle_material = above_left_ff.second_material;
         if (above_left_ff.split_flag) begin
            tri_sel.corner_pattern = PAT_SPLIT_SECOND;
            tri_sel.height_one     = ul;
            tri_sel.height_two     = lr;
            tri_sel.height_three   = ur;
         end else begin
            tri_sel.corner_pattern = PAT_UNSPLIT_SECOND;
            tri_sel.height_one     = ll;
            tri_sel.height_two     = lr;
            tri_sel.height_three   = ur;
         end
      end
   end

   // Next state of the work register and the neighbor history.
   always_comb begin
      a_valid_in      = load ? 1'b1 : (a_retire ? 1'b0 : a_valid_ff);
      a_first_done_in = a_first_done_ff;
      if (load || a_retire) begin
         a_first_done_in = 1'b0;
      end else if (emit_fire && has_first) begin
         a_first_done_in = 1'b1;
      end
      above_left_in  = a_retire ? up_right : above_left_ff;
      left_height_in = a_retire ? a_sample_ff.sample_height : left_height_ff;
      rsp_valid_in   = emit_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         a_first_done_ff <= 1'b0;
         above_left_ff   <= '0;
         left_height_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         a_valid_ff      <= a_valid_in;
         a_first_done_ff <= a_first_done_in;
         above_left_ff   <= above_left_in;
         left_height_ff  <= left_height_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         a_sample_ff <= sample;
         a_pos_ff    <= position;
      end
      if (emit_fire) begin
         rsp_tri_ff <= tri_sel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tri   = rsp_tri_ff;

   // A hole material is never sent.
   `HTE_ASSERT(a_no_hole, clock, reset,
      rsp_valid_ff |-> (rsp_tri_ff.triangle_material != HOLE_MATERIAL),
      "hole material in result")
   // A second triangle always closes its cell.
   `HTE_ASSERT(a_second_is_last, clock, reset,
      (rsp_valid_ff && rsp_tri_ff.corner_pattern[0]) |-> rsp_tri_ff.last_of_cell,
      "second triangle not marked last")
   // A first triangle that is not last is followed by its partner.
   `HTE_ASSERT(a_pair_follows, clock, reset,
      (rsp_valid_ff && !rsp_tri_ff.last_of_cell) |=> rsp_valid_ff,
      "second triangle of a cell missing")
   // The half-sent mark only exists while a sample is held.
   `HTE_NEVER(a_done_without_item, clock, reset, a_first_done_ff && !a_valid_ff,
      "half-sent mark without a held sample")

endmodule

FILE: sv/heightfield_triangle_emitter.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_emitter
// Turns a row-major stream of heightfield samples into a triangle stream.
// ----------------------------------------------------------------------------
// A sample is taken on every cycle in which its cell yields at most one
// triangle and the result register is not stalled; a sample whose cell
// carries two triangles holds the work register until both have left
// through the single result register. The first triangle of a sample is
// loaded from the work register into the result register once it is free. The
// previous row lives in a 1024 x 31 single-port line store that is read and
// rewritten at the same column on each input transfer; it needs no clearing
// after reset, since row 0 starts no cell. Configuration writes are taken in
// any cycle (csr_ready is always high) but must only be issued while idle.
`timescale 1ns / 1ps

module heightfield_triangle_emitter (
   input  logic                                clock,
   input  logic                                reset,
   // Sample input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [hte_pkg::HEIGHT_W-1:0] req_sample_height,
   input  logic                                req_split_flag,
   input  logic [hte_pkg::MAT_W-1:0]           req_first_material,
   input  logic [hte_pkg::MAT_W-1:0]           req_second_material,
   // Triangle output channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hte_pkg::COL_W-1:0]           rsp_cell_column,
   output logic [hte_pkg::ROW_W-1:0]           rsp_cell_row,
   output logic [1:0]                          rsp_corner_pattern,
   output logic signed [hte_pkg::HEIGHT_W-1:0] rsp_height_one,
   output logic signed [hte_pkg::HEIGHT_W-1:0] rsp_height_two,
   output logic signed [hte_pkg::HEIGHT_W-1:0] rsp_height_three,
   output logic [hte_pkg::MAT_W-1:0]           rsp_triangle_material,
   output logic                                rsp_last_of_cell,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hte_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hte_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hte_pkg::*;

   logic         req_transfer, csr_transfer, work_free;
   sample_type   sample, up_right;
   position_type position;
   triangle_type rsp_tri;

   // Input transfer happens whenever the work register can take a sample.
   assign req_stall    = !work_free;
   assign req_transfer = req_valid && work_free;
   assign csr_ready    = 1'b1;
   assign csr_transfer = csr_valid;

   assign sample.sample_height   = req_sample_height;
   assign sample.split_flag      = req_split_flag;
   assign sample.first_material  = req_first_material;
   assign sample.second_material = req_second_material;

   // Position counters and configuration registers.
   hte_position u_position (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_transfer),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (req_transfer),
      .position  (position)
   );

   // Previous-row storage.
   hte_line_store u_line_store (
      .clock      (clock),
      .access     (req_transfer),
      .address    (position.column),
      .write_data (sample),
      .read_data  (up_right)
   );

   // Cell assembly and result register.
   hte_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (req_transfer),
      .sample    (sample),
      .position  (position),
      .up_right  (up_right),
      .free      (work_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tri   (rsp_tri)
   );

   assign rsp_cell_column       = rsp_tri.cell_column;
   assign rsp_cell_row          = rsp_tri.cell_row;
   assign rsp_corner_pattern    = rsp_tri.corner_pattern;
   assign rsp_height_one        = rsp_tri.height_one;
   assign rsp_height_two        = rsp_tri.height_two;
   assign rsp_height_three      = rsp_tri.height_three;
   assign rsp_triangle_material = rsp_tri.triangle_material;
   assign rsp_last_of_cell      = rsp_tri.last_of_cell;

endmodule

FILE: sim/tb_heightfield_triangle_emitter.sv
// ----------------------------------------------------------------------------
// tb_heightfield_triangle_emitter
// Self-checking testbench for the heightfield triangle emitter. Samples are
// sent through the request channel. A local line-store predictor turns each
// accepted sample into the triangles it must produce. Every triangle transfer
// is compared field by field against the oldest prediction. Traffic runs with
// and without sender gaps and receiver stalls, under several grid shapes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heightfield_triangle_emitter;
   import hte_pkg::*;

   localparam int CLOCK_HALF_NS = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int REPORT_LIMIT  = 10;

   // Clock, reset and block ports.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   sample_type                 req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b0;
   logic [COL_W-1:0]           rsp_cell_column;
   logic [ROW_W-1:0]           rsp_cell_row;
   logic [1:0]                 rsp_corner_pattern;
   logic signed [HEIGHT_W-1:0] rsp_height_one;
   logic signed [HEIGHT_W-1:0] rsp_height_two;
   logic signed [HEIGHT_W-1:0] rsp_height_three;
   logic [MAT_W-1:0]           rsp_triangle_material;
   logic                       rsp_last_of_cell;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index  = '0;
   logic [CSR_DATA_W-1:0]      csr_data   = '0;

   // Predictor state: registers, previous row and cell corners.
   logic [COL_CNT_W-1:0]       grid_columns_reg   = COLUMN_COUNT_RESET;
   logic [ROW_W-1:0]           grid_rows_reg      = ROW_COUNT_RESET;
   sample_type                 prev_row [MAX_COLUMNS];
   sample_type                 diag_entry         = '0;
   logic signed [HEIGHT_W-1:0] left_sample_height = '0;
   int unsigned                next_column        = 0;
   int unsigned                next_row           = 0;
   triangle_type               expected_triangles [$];

   // Traffic shaping and bookkeeping.
   int send_gap_pct      = 0;
   int stall_pct         = 0;
   int samples_sent      = 0;
   int triangles_checked = 0;
   int register_writes   = 0;
   int fail_count        = 0;

   heightfield_triangle_emitter u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_height     (req_sample.sample_height),
      .req_split_flag        (req_sample.split_flag),
      .req_first_material    (req_sample.first_material),
      .req_second_material   (req_sample.second_material),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_cell_column       (rsp_cell_column),
      .rsp_cell_row          (rsp_cell_row),
      .rsp_corner_pattern    (rsp_corner_pattern),
      .rsp_height_one        (rsp_height_one),
      .rsp_height_two        (rsp_height_two),
      .rsp_height_three      (rsp_height_three),
      .rsp_triangle_material (rsp_triangle_material),
      .rsp_last_of_cell      (rsp_last_of_cell),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   // Record a failure; only the first few are printed.
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
      end
   endfunction

   // Work out the triangles that one accepted sample completes, then advance
   // the grid position with the clamped column and row counts.
   function automatic void predict_triangles(input sample_type s);
      int unsigned  cols;
      int unsigned  rows;
      sample_type   up_right;
      triangle_type t_out;
      cols = (grid_columns_reg < COLUMN_COUNT_MIN) ? 32'(COLUMN_COUNT_MIN) :
             (grid_columns_reg > COLUMN_COUNT_MAX) ? 32'(MAX_COLUMNS) :
             32'(grid_columns_reg);
      rows = 32'((grid_rows_reg < ROW_COUNT_MIN) ? ROW_COUNT_MIN : grid_rows_reg);
      up_right = prev_row[COL_W'(next_column)];

      if (next_row >= 1 && next_column >= 1) begin
         t_out = '0;
         t_out.cell_column = COL_W'(next_column - 1);
         t_out.cell_row    = ROW_W'(next_row - 1);
         // First triangle of the cell.
         if (diag_entry.first_material != HOLE_MATERIAL) begin
            t_out.triangle_material = diag_entry.first_material;
            t_out.last_of_cell      = (diag_entry.second_material == HOLE_MATERIAL);
            if (diag_entry.split_flag) begin
               t_out.corner_pattern = PAT_SPLIT_FIRST;
               t_out.height_one     = diag_entry.sample_height;
               t_out.height_two     = left_sample_height;
               t_out.height_three   = s.sample_height;
            end else begin
               t_out.corner_pattern = PAT_UNSPLIT_FIRST;
               t_out.height_one     = up_right.sample_height;
               t_out.height_two     = diag_entry.sample_height;
               t_out.height_three   = left_sample_height;
            end
            expected_triangles.push_back(t_out);
         end
         // Second triangle of the cell always closes it.
         if (diag_entry.second_material != HOLE_MATERIAL) begin
            t_out.triangle_material = diag_entry.second_material;
            t_out.last_of_cell      = 1'b1;
            if (diag_entry.split_flag) begin
               t_out.corner_pattern = PAT_SPLIT_SECOND;
               t_out.height_one     = diag_entry.sample_height;
               t_out.height_two     = s.sample_height;
               t_out.height_three   = up_right.sample_height;
            end else begin
               t_out.corner_pattern = PAT_UNSPLIT_SECOND;
               t_out.height_one     = left_sample_height;
               t_out.height_two     = s.sample_height;
               t_out.height_three   = up_right.sample_height;
            end
            expected_triangles.push_back(t_out);
         end
      end

      diag_entry                        = up_right;
      prev_row[COL_W'(next_column)]     = s;
      left_sample_height                = s.sample_height;
      if (next_column + 1 >= cols) begin
         next_column = 0;
         next_row    = (next_row + 1 >= rows) ? 0 : next_row + 1;
      end else begin
         next_column++;
      end
   endfunction

   // Materials lean toward holes and the range ends.
   function automatic logic [MAT_W-1:0] random_material();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return HOLE_MATERIAL;
      if (pick < 25) return '0;
      if (pick < 30) return HOLE_MATERIAL - MAT_W'(1);
      return MAT_W'($urandom_range(126));
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int         pick;
      pick = $urandom_range(9);
      if (pick == 0) s.sample_height = 16'sh8000;
      else if (pick == 1) s.sample_height = 16'sh7FFF;
      else s.sample_height = HEIGHT_W'($urandom);
      s.split_flag      = 1'($urandom_range(1));
      s.first_material  = random_material();
      s.second_material = random_material();
      return s;
   endfunction

   // Send one sample, with random idle cycles in front, and predict it
   // once the transfer has happened.
   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      predict_triangles(s);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_COLUMN_COUNT) grid_columns_reg = value[COL_CNT_W-1:0];
      else grid_rows_reg = value[ROW_W-1:0];
      register_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every predicted triangle has arrived, then give a sample
   // that yields nothing time to leave the pipeline.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_triangles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Bring the grid position back to its origin with minimal counts, so that
   // a new grid never reads a line store entry that was not written, then
   // program the requested shape.
   task automatic start_grid(input logic [CSR_DATA_W-1:0] columns_value,
                             input logic [CSR_DATA_W-1:0] rows_value);
      wait_drained();
      write_register(CSR_COLUMN_COUNT, CSR_DATA_W'($urandom_range(2)));
      write_register(CSR_ROW_COUNT, CSR_DATA_W'($urandom_range(2)));
      while (next_column != 0 || next_row != 0) send_sample(random_sample());
      wait_drained();
      write_register(CSR_COLUMN_COUNT, columns_value);
      write_register(CSR_ROW_COUNT, rows_value);
   endtask

   // Reset shape (2 x 2): one cell per grid, covering all corner patterns,
   // each single hole, both holes and the height extremes.
   task automatic test_cell_patterns();
      logic             split_case  [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      logic [MAT_W-1:0] first_case  [5] = '{7'd0, 7'd126, HOLE_MATERIAL, 7'd9,
                                            HOLE_MATERIAL};
      logic [MAT_W-1:0] second_case [5] = '{7'd126, 7'd0, 7'd5, HOLE_MATERIAL,
                                            HOLE_MATERIAL};
      logic signed [HEIGHT_W-1:0] corner_heights [4] = '{16'sh7FFF, 16'sh8000,
                                                         -16'sd1, 16'sd0};
      sample_type s;
      for (int k = 0; k < 5; k++) begin
         for (int corner = 0; corner < 4; corner++) begin
            s = random_sample();
            s.sample_height = corner_heights[2'(corner + k)];
            if (corner == 0) begin
               s.split_flag      = split_case[3'(k)];
               s.first_material  = first_case[3'(k)];
               s.second_material = second_case[3'(k)];
            end
            send_sample(s);
         end
      end
   endtask

   // Counts below the minimum, masked upper bits and the largest row count.
   task automatic test_register_limits();
      start_grid(16'd0, 16'd1);
      repeat (8) send_sample(random_sample());
      start_grid(16'hF804, 16'hFFFF);
      repeat (24) send_sample(random_sample());
      start_grid(16'd1, 16'd3);
      repeat (12) send_sample(random_sample());
   endtask

   // Shrink both counts while the position lies beyond the new bounds.
   task automatic test_midgrid_change();
      start_grid(16'd6, 16'd5);
      repeat (15) send_sample(random_sample());
      wait_drained();
      write_register(CSR_COLUMN_COUNT, 16'd3);
      write_register(CSR_ROW_COUNT, 16'd2);
      repeat (12) send_sample(random_sample());
   endtask

   // An oversized count acts as the widest row: a run of samples stays in
   // row 0 and completes no cell.
   task automatic test_widest_grid();
      send_gap_pct = 0;
      stall_pct    = 0;
      start_grid(16'h07FF, 16'd2);
      repeat (40) send_sample(random_sample());
   endtask

   // Random shapes under each pacing mode.
   task automatic test_random_traffic();
      int gap_mode   [4] = '{0, 63, 0, 22};
      int stall_mode [4] = '{0, 0, 63, 22};
      logic [CSR_DATA_W-1:0] width_value;
      for (int mode = 0; mode < 4; mode++) begin
         send_gap_pct = gap_mode[2'(mode)];
         stall_pct    = stall_mode[2'(mode)];
         for (int shape = 0; shape < 2; shape++) begin
            width_value = CSR_DATA_W'(($urandom_range(99) < 80) ? $urandom_range(2, 9)
                                                                : $urandom_range(10, 40));
            start_grid(width_value, CSR_DATA_W'($urandom_range(2, 6)));
            repeat (40) send_sample(random_sample());
         end
      end
   endtask

   // Receiver stalls at the rate of the current pacing mode.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each triangle transfer with the oldest prediction.
   always @(posedge clock) begin : result_check
      triangle_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_triangles.size() == 0) begin
            note_failure("triangle transfer with nothing predicted");
         end else begin
            want = expected_triangles.pop_front();
            check_field("cell_column", 16'(want.cell_column), 16'(rsp_cell_column));
            check_field("cell_row", want.cell_row, rsp_cell_row);
            check_field("corner_pattern", 16'(want.corner_pattern),
                        16'(rsp_corner_pattern));
            check_field("height_one", want.height_one, rsp_height_one);
            check_field("height_two", want.height_two, rsp_height_two);
            check_field("height_three", want.height_three, rsp_height_three);
            check_field("triangle_material", 16'(want.triangle_material),
                        16'(rsp_triangle_material));
            check_field("last_of_cell", 16'(want.last_of_cell), 16'(rsp_last_of_cell));
            triangles_checked++;
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_cell_patterns();
      test_register_limits();
      test_midgrid_change();
      test_widest_grid();
      test_random_traffic();
      wait_drained();
      $display("Sent %0d samples, checked %0d triangles, made %0d register writes.",
               samples_sent, triangles_checked, register_writes);
      $display("Covered every corner pattern, clamped and mid-grid counts, four pacing modes.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d triangles outstanding.", expected_triangles.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/hte_pkg.sv
sv/hte_position.sv
sv/hte_line_store.sv
sv/hte_emit.sv
sv/heightfield_triangle_emitter.sv
sim/tb_heightfield_triangle_emitter.sv
